[src/scaled_decimal_compare_macros.svh]
// Assertion macros shared by the compare pipeline.
// IMPL checks the consequent in the same cycle, NEXT checks it in the cycle after.
`ifndef SCALED_DECIMAL_COMPARE_MACROS_SVH
`define SCALED_DECIMAL_COMPARE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SDC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scaled_decimal_compare: assertion failed");
`define SDC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scaled_decimal_compare: assertion failed");
`else
`define SDC_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define SDC_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

[src/sdc_pkg.sv]
package sdc_pkg;

    localparam int MAX_SCALE = 28;
    localparam int SCALE_W   = 5;
    localparam int MANT_LO_W = 64;
    localparam int MANT_HI_W = 32;
    localparam int MANT_W    = MANT_LO_W + MANT_HI_W;
    localparam int LIMB_W    = 32;
    localparam int LIMBS     = MANT_W / LIMB_W;
    localparam int PP_W      = 2 * LIMB_W;
    // 10^28 needs 94 bits
    localparam int POW_W     = 94;
    localparam int ROW_W     = LIMB_W + MANT_W;
    localparam int SUM_W     = ROW_W + 2 * LIMB_W;
    localparam int PROD_W    = MANT_W + POW_W;

    typedef logic [POW_W-1:0] t_pow;
    typedef t_pow [MAX_SCALE:0] t_pow_tab;

    function automatic t_pow_tab build_pow10();
        t_pow_tab tab;
        t_pow     p;
        p = t_pow'(1);
        for (int k = 0; k <= MAX_SCALE; k++) begin
            tab[k] = p;
            p = t_pow'(p * t_pow'(10));
        end
        return tab;
    endfunction

    localparam t_pow_tab POW10 = build_pow10();

    typedef struct packed {
        logic [MANT_W-1:0] other;
        logic              a_scaled;
        logic              neg_a;
        logic              neg_b;
    } t_side;

    typedef struct packed {
        logic [MANT_W-1:0] scaled;
        t_pow              pow;
        t_side             side;
    } t_align;

    typedef struct packed {
        logic [PROD_W-1:0] product;
        t_side             side;
    } t_prod;

endpackage

[src/sdc_ifs.sv]
interface sdc_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] first_mantissa_low;
    logic [31:0] first_mantissa_high;
    logic [4:0]  first_scale;
    logic        first_negative;
    logic [63:0] second_mantissa_low;
    logic [31:0] second_mantissa_high;
    logic [4:0]  second_scale;
    logic        second_negative;

    modport source (
        output valid, first_mantissa_low, first_mantissa_high, first_scale, first_negative,
               second_mantissa_low, second_mantissa_high, second_scale, second_negative,
        input  ready
    );
    modport sink (
        input  valid, first_mantissa_low, first_mantissa_high, first_scale, first_negative,
               second_mantissa_low, second_mantissa_high, second_scale, second_negative,
        output ready
    );
endinterface

interface sdc_out_if;
    logic valid;
    logic ready;
    logic is_less;
    logic is_equal;
    logic is_less_or_equal;

    modport source (
        output valid, is_less, is_equal, is_less_or_equal,
        input  ready
    );
    modport sink (
        input  valid, is_less, is_equal, is_less_or_equal,
        output ready
    );
endinterface

[src/scaled_decimal_compare.sv]
// Pipeline: align, four multiply/accumulate stages for the 96 x 94 bit
//   scaling product, compare. Throughput: one item per cycle while the
//   output is ready; every stage holds its own valid bit, so bubbles
//   collapse and input is taken while a finished result waits.
// Reset: synchronous, active low; clears all stage valid bits, no data state.
module scaled_decimal_compare (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sdc_in_if.sink    i_in,
    sdc_out_if.source o_out
);

    sdc_pkg::t_align align_data;
    logic            align_valid;
    logic            mul_ready;
    sdc_pkg::t_prod  prod_data;
    logic            prod_valid;
    logic            cmp_ready;

    sdc_align u_align (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_data  (align_data),
        .o_valid (align_valid),
        .i_ready (mul_ready)
    );

    sdc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (align_data),
        .i_valid (align_valid),
        .o_ready (mul_ready),
        .o_data  (prod_data),
        .o_valid (prod_valid),
        .i_ready (cmp_ready)
    );

    sdc_cmp u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (prod_data),
        .i_valid (prod_valid),
        .o_ready (cmp_ready),
        .o_out   (o_out)
    );

endmodule

[src/sdc_align.sv]
module sdc_align (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sdc_in_if.sink          i_in,
    output sdc_pkg::t_align o_data,
    output logic            o_valid,
    input  logic            i_ready
);

    localparam int SW = sdc_pkg::SCALE_W;
    localparam int MW = sdc_pkg::MANT_W;

    logic [SW-1:0]   sa;
    logic [SW-1:0]   sb;
    logic [SW-1:0]   diff;
    logic [MW-1:0]   ma;
    logic [MW-1:0]   mb;
    logic            a_scaled;
    sdc_pkg::t_align n_data;
    sdc_pkg::t_align r_data;
    logic            r_valid;

    always_comb begin
        sa = (i_in.first_scale > SW'(sdc_pkg::MAX_SCALE)) ?
             SW'(sdc_pkg::MAX_SCALE) : i_in.first_scale;
        sb = (i_in.second_scale > SW'(sdc_pkg::MAX_SCALE)) ?
             SW'(sdc_pkg::MAX_SCALE) : i_in.second_scale;
        ma = {i_in.first_mantissa_high, i_in.first_mantissa_low};
        mb = {i_in.second_mantissa_high, i_in.second_mantissa_low};
        // the operand with fewer decimal places gets scaled up
        a_scaled = (sa < sb);
        diff     = a_scaled ? (sb - sa) : (sa - sb);

        n_data.pow            = sdc_pkg::POW10[diff];
        n_data.scaled         = a_scaled ? ma : mb;
        n_data.side.other     = a_scaled ? mb : ma;
        n_data.side.a_scaled  = a_scaled;
        // zero of either sign counts as non-negative
        n_data.side.neg_a     = i_in.first_negative && (ma != '0);
        n_data.side.neg_b     = i_in.second_negative && (mb != '0);
    end

    assign i_in.ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_data <= n_data;
        end
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;

endmodule

[src/sdc_mul.sv]
`include "scaled_decimal_compare_macros.svh"

module sdc_mul (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sdc_pkg::t_align i_data,
    input  logic            i_valid,
    output logic            o_ready,
    output sdc_pkg::t_prod  o_data,
    output logic            o_valid,
    input  logic            i_ready
);

    localparam int LW = sdc_pkg::LIMB_W;
    localparam int NL = sdc_pkg::LIMBS;
    localparam int MW = sdc_pkg::MANT_W;
    localparam int PW = sdc_pkg::PP_W;
    localparam int RW = sdc_pkg::ROW_W;
    localparam int SW = sdc_pkg::SUM_W;
    localparam int QW = sdc_pkg::PROD_W;

    // stage A: 32x32 partial products
    logic [MW-1:0]  pow_x;
    logic [PW-1:0]  n_pp [NL][NL];
    logic [PW-1:0]  r_pp [NL][NL];
    sdc_pkg::t_side r_side_a;
    logic           r_v_a;
    // stage B: one row per limb of the scaled mantissa
    logic [RW-1:0]  n_row [NL];
    logic [RW-1:0]  r_row [NL];
    sdc_pkg::t_side r_side_b;
    logic           r_v_b;
    // stage C: outer rows summed
    logic [SW-1:0]  n_sum;
    logic [SW-1:0]  r_sum;
    logic [RW-1:0]  r_row_mid;
    sdc_pkg::t_side r_side_c;
    logic           r_v_c;
    // stage D: full product
    logic [SW-1:0]  n_prod;
    sdc_pkg::t_prod r_prod;
    logic           r_v_d;

    logic rdy_a;
    logic rdy_b;
    logic rdy_c;
    logic rdy_d;

    assign rdy_d   = !r_v_d || i_ready;
    assign rdy_c   = !r_v_c || rdy_d;
    assign rdy_b   = !r_v_b || rdy_c;
    assign rdy_a   = !r_v_a || rdy_b;
    assign o_ready = rdy_a;

    always_comb begin
        pow_x = MW'(i_data.pow);
        for (int i = 0; i < NL; i++) begin
            for (int j = 0; j < NL; j++) begin
                n_pp[i][j] = PW'(i_data.scaled[i*LW +: LW]) * PW'(pow_x[j*LW +: LW]);
            end
        end
    end

    always_comb begin
        // products 0 and 2 of a row do not overlap, product 1 sits between
        for (int i = 0; i < NL; i++) begin
            n_row[i] = {r_pp[i][2], r_pp[i][0]} + RW'({r_pp[i][1], {LW{1'b0}}});
        end
    end

    assign n_sum  = {r_row[2], {(2*LW){1'b0}}} + SW'(r_row[0]);
    assign n_prod = r_sum + SW'({r_row_mid, {LW{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
            r_v_c <= 1'b0;
            r_v_d <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_v_a <= i_valid;
            end
            if (rdy_b) begin
                r_v_b <= r_v_a;
            end
            if (rdy_c) begin
                r_v_c <= r_v_b;
            end
            if (rdy_d) begin
                r_v_d <= r_v_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_pp     <= n_pp;
            r_side_a <= i_data.side;
        end
        if (rdy_b) begin
            r_row    <= n_row;
            r_side_b <= r_side_a;
        end
        if (rdy_c) begin
            r_sum     <= n_sum;
            r_row_mid <= r_row[1];
            r_side_c  <= r_side_b;
        end
        if (rdy_d) begin
            r_prod.product <= n_prod[QW-1:0];
            r_prod.side    <= r_side_c;
        end
    end

    assign o_data  = r_prod;
    assign o_valid = r_v_d;

    `SDC_ASSERT_NEXT(a_prod_hold, i_clk, i_rst_n, r_v_d && !i_ready, r_v_d && $stable(r_prod))
    `SDC_ASSERT_NEXT(a_stage_c_hold, i_clk, i_rst_n, r_v_c && !rdy_d, r_v_c && $stable(r_sum))

endmodule

[src/sdc_cmp.sv]
`include "scaled_decimal_compare_macros.svh"

module sdc_cmp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sdc_pkg::t_prod i_data,
    input  logic           i_valid,
    output logic           o_ready,
    sdc_out_if.source      o_out
);

    localparam int QW = sdc_pkg::PROD_W;

    logic [QW-1:0] mag_a;
    logic [QW-1:0] mag_b;
    logic          mag_lt;
    logic          mag_eq;
    logic          n_less;
    logic          n_equal;
    logic          r_less;
    logic          r_equal;
    logic          r_less_eq;
    logic          r_valid;

    always_comb begin
        mag_a  = i_data.side.a_scaled ? i_data.product : QW'(i_data.side.other);
        mag_b  = i_data.side.a_scaled ? QW'(i_data.side.other) : i_data.product;
        mag_lt = (mag_a < mag_b);
        mag_eq = (mag_a == mag_b);
        unique case ({i_data.side.neg_a, i_data.side.neg_b})
            2'b10: begin
                n_less  = 1'b1;
                n_equal = 1'b0;
            end
            2'b01: begin
                n_less  = 1'b0;
                n_equal = 1'b0;
            end
            2'b11: begin
                // both negative: larger magnitude is the smaller value
                n_less  = !mag_lt && !mag_eq;
                n_equal = mag_eq;
            end
            default: begin
                n_less  = mag_lt;
                n_equal = mag_eq;
            end
        endcase
    end

    assign o_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_less    <= n_less;
            r_equal   <= n_equal;
            r_less_eq <= n_less || n_equal;
        end
    end

    assign o_out.valid            = r_valid;
    assign o_out.is_less          = r_less;
    assign o_out.is_equal         = r_equal;
    assign o_out.is_less_or_equal = r_less_eq;

    `SDC_ASSERT_NEXT(a_mixed_sign, i_clk, i_rst_n, i_valid && o_ready && i_data.side.neg_a && !i_data.side.neg_b, r_valid && r_less && !r_equal)
    `SDC_ASSERT_IMPL(a_lt_eq_excl, i_clk, i_rst_n, r_valid, !(r_less && r_equal))
    `SDC_ASSERT_IMPL(a_le_join, i_clk, i_rst_n, r_valid, r_less_eq == (r_less || r_equal))

endmodule
